@@ sv/pts_pkg.sv @@
// Shared types and constants for the periodic timer scheduler.
package pts_pkg;

   localparam int DEF_MAX_TIMERS = 16;
   localparam int DEF_MAX_FIRES  = 16;
   localparam int US_PER_MS      = 1000;

   localparam int MODE_W   = 2;
   localparam int TID_W    = 4;
   localparam int IVAL_W   = 31;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 2;
   localparam int QUO_W    = 22;
   localparam int REM_W    = 10;

   localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSTALL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_DUPLICATE   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_PRESENT = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP,
      CELL_MARK,
      CELL_SWEEP
   } cell_op_type;

   // One queue entry: a timer id and its due time.
   typedef struct packed {
      logic              valid;
      logic [TID_W-1:0]  id;
      logic [TIME_W-1:0] due;
   } entry_type;

   // Command broadcast to every cell of the queue.
   typedef struct packed {
      cell_op_type       op;
      logic [TID_W-1:0]  id;
      logic [TIME_W-1:0] due;
   } cell_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_INS,
      ST_MARK,
      ST_SWEEP,
      ST_TCHK,
      ST_TFIRE,
      ST_TINS,
      ST_EMIT
   } state_type;

endpackage

@@ sv/pts_if.sv @@
// Request and response channel interfaces.
interface pts_req_if;
   logic                        valid;
   logic                        ready;
   logic [pts_pkg::MODE_W-1:0]  mode;
   logic [pts_pkg::TID_W-1:0]   timer_id;
   logic [pts_pkg::IVAL_W-1:0]  interval_us;
   logic [pts_pkg::TIME_W-1:0]  now_ms;

   modport source (output valid, mode, timer_id, interval_us, now_ms, input ready);
   modport sink (input valid, mode, timer_id, interval_us, now_ms, output ready);
endinterface

interface pts_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          fired;
   logic [pts_pkg::TID_W-1:0]     fired_id;
   logic [pts_pkg::STATUS_W-1:0]  status;
   logic                          last;

   modport source (output valid, fired, fired_id, status, last, input ready);
   modport sink (input valid, fired, fired_id, status, last, output ready);
endinterface

@@ sv/pts_cell.sv @@
// One cell of the sorted timer queue.
module pts_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  pts_pkg::cell_cmd_type cmd,
   input  pts_pkg::entry_type    left_data,
   input  logic                  left_keep,
   input  logic                  left_hole,
   input  pts_pkg::entry_type    right_data,
   output pts_pkg::entry_type    data,
   output logic                  keep,
   output logic                  hole
);
   import pts_pkg::*;

   entry_type entry_ff, entry_in;
   logic      hole_ff, hole_in;

   // The entry stays in place on insert when it is due no later than the new one.
   assign keep = entry_ff.valid && (entry_ff.due <= cmd.due);
   assign data = entry_ff;
   assign hole = hole_ff;

   // Next entry and hole marker.
   always_comb begin
      entry_in = entry_ff;
      hole_in  = hole_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  entry_in.valid = 1'b1;
                  entry_in.id    = cmd.id;
                  entry_in.due   = cmd.due;
               end else begin
                  entry_in = left_data;
               end
            end
         end
         CELL_POP: begin
            entry_in = right_data;
         end
         CELL_MARK: begin
            hole_in = entry_ff.valid && (entry_ff.id == cmd.id);
         end
         CELL_SWEEP: begin
            if (hole_ff) begin
               entry_in = right_data;
            end
            hole_in = left_hole;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         hole_ff        <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
         hole_ff        <= hole_in;
      end
      entry_ff.id  <= entry_in.id;
      entry_ff.due <= entry_in.due;
   end

endmodule

@@ sv/pts_div.sv @@
// Divider of an interval by one thousand using a reciprocal multiplication.
module pts_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pts_pkg::IVAL_W-1:0]   dividend,
   output logic                         done,
   output logic [pts_pkg::QUO_W-1:0]    quotient,
   output logic [pts_pkg::REM_W-1:0]    remainder
);
   import pts_pkg::*;

   // Dividing by 1000 is a shift by 3 followed by a division by 125. The
   // division by 125 multiplies by ceil(2^35 / 125) and keeps the bits from
   // 35 up, which is exact for every 28-bit value.
   localparam int XS_W    = IVAL_W - 3;
   localparam int RECIP_W = 29;
   localparam int SHIFT   = 35;
   localparam int PROD_W  = XS_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = 29'd274877907;

   logic              busy_ff, busy_in;
   logic [IVAL_W-1:0] x_ff, x_in;
   logic [QUO_W-1:0]  q_ff, q_in;
   logic [PROD_W-1:0] prod;
   logic [TIME_W-1:0] rem_full;

   // Quotient from the captured dividend, registered in the cycle after it is captured.
   always_comb begin
      prod    = PROD_W'(x_ff[IVAL_W-1:3]) * PROD_W'(RECIP);
      busy_in = start;
      x_in    = start ? dividend : x_ff;
      q_in    = busy_ff ? prod[SHIFT +: QUO_W] : q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff <= x_in;
      q_ff <= q_in;
   end

   // Remainder from the dividend and the registered quotient.
   assign rem_full  = TIME_W'(x_ff) - TIME_W'(q_ff) * TIME_W'(US_PER_MS);
   assign done      = !busy_ff;
   assign quotient  = q_ff;
   assign remainder = rem_full[REM_W-1:0];

endmodule

@@ sv/periodic_timer_scheduler.sv @@
// Top level of the periodic timer scheduler: control, slot tables and queue.
//
// Usage: requests arrive on req_chan (valid/ready); responses leave on
// rsp_chan (valid/ready). A request is taken only while the block is idle.
// An install divides the interval by one thousand with a shift and a
// reciprocal multiplication and then inserts the timer into the sorted
// queue; its response is given from the EMIT state after the insert.
// A remove marks the queue entry and sweeps a hole through the row of cells.
// A tick checks the queue head and, for each firing, pops the head,
// advances its due time and reinserts it, passing through the TCHK, TFIRE
// and TINS states in turn. Each firing gives one response; the final response
// of a request carries last. A tick that fires nothing, an install, a
// remove and an unused mode each give exactly one response.
// The response sits in an output register; when the receiver stalls, the
// block holds its work at the next response until that register frees.
// Reset empties the queue and disarms every timer; it takes effect at
// once and needs no clearing pass.
module periodic_timer_scheduler #(
   parameter int MAX_TIMERS         = pts_pkg::DEF_MAX_TIMERS,
   parameter int MAX_FIRES_PER_TICK = pts_pkg::DEF_MAX_FIRES
) (
   input  logic      clock,
   input  logic      reset,
   pts_req_if.sink   req_chan,
   pts_rsp_if.source rsp_chan
);
   import pts_pkg::*;

   localparam int SIW  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int EW   = (SIW > TID_W) ? SIW : TID_W;
   localparam int SWW  = $clog2(MAX_TIMERS + 1);
   localparam int FCW  = $clog2(MAX_FIRES_PER_TICK + 1);

   state_type state_ff, state_in;

   // Captured request.
   logic [TID_W-1:0]    id_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [STATUS_W-1:0] status_ff, status_in;

   // Slot tables.
   logic              active_ff [MAX_TIMERS];
   logic [QUO_W-1:0]  q_ff      [MAX_TIMERS];
   logic [REM_W-1:0]  r_ff      [MAX_TIMERS];
   logic [REM_W-1:0]  frac_ff   [MAX_TIMERS];

   // Tick bookkeeping.
   logic [FCW-1:0]    fire_cnt_ff;
   logic              pend_ff;
   logic [TID_W-1:0]  cap_id_ff;
   logic [TIME_W-1:0] cap_due_ff;
   logic [TIME_W-1:0] new_due_ff;
   logic [SWW-1:0]    sweep_ff;

   // Response register.
   logic                rsp_valid_ff;
   logic                rsp_fired_ff;
   logic [TID_W-1:0]    rsp_id_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_last_ff;

   logic                emit;
   logic                emit_fired;
   logic [TID_W-1:0]    emit_id;
   logic [STATUS_W-1:0] emit_status;
   logic                emit_last;

   logic accept, can_emit, due_now, fire_go;
   logic [EW-1:0] req_ide, cap_ide;
   logic [EW-1:0] in_ide;
   logic          in_ok, in_on;

   // Divider.
   logic             div_done;
   logic [QUO_W-1:0] div_q;
   logic [REM_W-1:0] div_r;

   // Queue of cells.
   cell_cmd_type cmd;
   entry_type    cell_data [MAX_TIMERS];
   logic         cell_keep [MAX_TIMERS];
   logic         cell_hole [MAX_TIMERS];

   logic [REM_W:0]    frac_sum;
   logic              frac_carry;

   assign accept   = req_chan.valid && req_chan.ready;
   assign can_emit = !rsp_valid_ff || rsp_chan.ready;

   // Slot index views of the captured and incoming ids.
   assign req_ide = EW'(id_ff);
   assign cap_ide = EW'(cap_id_ff);
   assign in_ide  = EW'(req_chan.timer_id);
   assign in_ok   = 32'(req_chan.timer_id) < 32'(MAX_TIMERS);
   assign in_on   = in_ok && active_ff[in_ide[SIW-1:0]];

   // The head fires when it is due strictly before now and the cap allows.
   assign due_now = cell_data[0].valid && (cell_data[0].due < now_ff) &&
                    (fire_cnt_ff < FCW'(MAX_FIRES_PER_TICK));
   assign fire_go = due_now && (!pend_ff || can_emit);

   // Remainder carry for the firing timer.
   assign frac_sum   = {1'b0, frac_ff[cap_ide[SIW-1:0]]} + {1'b0, r_ff[cap_ide[SIW-1:0]]};
   assign frac_carry = frac_sum >= (REM_W+1)'(US_PER_MS);

   pts_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (req_chan.interval_us),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   genvar gi;
   generate
      for (gi = 0; gi < MAX_TIMERS; gi++) begin : g_cell
         entry_type left_d, right_d;
         logic      left_k, left_h;
         if (gi == 0) begin : g_first
            assign left_d = '0;
            assign left_k = 1'b1;
            assign left_h = 1'b0;
         end else begin : g_mid
            assign left_d = cell_data[gi-1];
            assign left_k = cell_keep[gi-1];
            assign left_h = cell_hole[gi-1];
         end
         if (gi == MAX_TIMERS - 1) begin : g_last
            assign right_d = '0;
         end else begin : g_inner
            assign right_d = cell_data[gi+1];
         end
         pts_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .left_data  (left_d),
            .left_keep  (left_k),
            .left_hole  (left_h),
            .right_data (right_d),
            .data       (cell_data[gi]),
            .keep       (cell_keep[gi]),
            .hole       (cell_hole[gi])
         );
      end
   endgenerate

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.mode)
                  MODE_TICK:    state_in = ST_TCHK;
                  MODE_INSTALL: state_in = (in_ok && !in_on) ? ST_DIV : ST_EMIT;
                  MODE_REMOVE:  state_in = in_on ? ST_MARK : ST_EMIT;
                  default:      state_in = ST_EMIT;
               endcase
            end
         end
         ST_DIV:   if (div_done) state_in = ST_INS;
         ST_INS:   state_in = ST_EMIT;
         ST_MARK:  state_in = ST_SWEEP;
         ST_SWEEP: if (sweep_ff == SWW'(1)) state_in = ST_EMIT;
         ST_EMIT:  if (can_emit) state_in = ST_IDLE;
         ST_TCHK: begin
            if (due_now) begin
               if (fire_go) state_in = ST_TFIRE;
            end else if (can_emit) begin
               state_in = ST_IDLE;
            end
         end
         ST_TFIRE: state_in = ST_TINS;
         ST_TINS:  state_in = ST_TCHK;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs of the state machine: queue command, response and status.
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      cmd.op         = CELL_HOLD;
      cmd.id         = id_ff;
      cmd.due        = now_ff + TIME_W'(div_q);
      emit           = 1'b0;
      emit_fired     = 1'b0;
      emit_id        = '0;
      emit_status    = STAT_OK;
      emit_last      = 1'b1;
      status_in      = STAT_OK;
      case (req_chan.mode)
         MODE_INSTALL: begin
            if (!in_ok) status_in = STAT_NOT_PRESENT;
            else if (in_on) status_in = STAT_DUPLICATE;
         end
         MODE_REMOVE: begin
            if (!in_on) status_in = STAT_NOT_PRESENT;
         end
         default: begin
         end
      endcase
      case (state_ff)
         ST_INS:   cmd.op = CELL_INSERT;
         ST_MARK:  cmd.op = CELL_MARK;
         ST_SWEEP: cmd.op = CELL_SWEEP;
         ST_TFIRE: cmd.op = CELL_POP;
         ST_TINS: begin
            cmd.op  = CELL_INSERT;
            cmd.id  = cap_id_ff;
            cmd.due = new_due_ff;
         end
         ST_EMIT: begin
            emit        = can_emit;
            emit_status = status_ff;
         end
         ST_TCHK: begin
            if (due_now) begin
               emit       = pend_ff && can_emit;
               emit_fired = 1'b1;
               emit_id    = cap_id_ff;
               emit_last  = 1'b0;
            end else begin
               emit       = can_emit;
               emit_fired = pend_ff;
               emit_id    = pend_ff ? cap_id_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         fire_cnt_ff  <= '0;
         sweep_ff     <= '0;
         for (int i = 0; i < MAX_TIMERS; i++) begin
            active_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            pend_ff     <= 1'b0;
            fire_cnt_ff <= '0;
         end else if (state_ff == ST_TCHK && fire_go) begin
            pend_ff     <= 1'b1;
            fire_cnt_ff <= fire_cnt_ff + 1'b1;
         end
         if (state_ff == ST_MARK) begin
            sweep_ff <= SWW'(MAX_TIMERS);
         end else if (state_ff == ST_SWEEP) begin
            sweep_ff <= sweep_ff - 1'b1;
         end
         if (state_ff == ST_INS) begin
            active_ff[req_ide[SIW-1:0]] <= 1'b1;
         end else if (state_ff == ST_MARK) begin
            active_ff[req_ide[SIW-1:0]] <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         id_ff     <= req_chan.timer_id;
         now_ff    <= req_chan.now_ms;
         status_ff <= status_in;
      end
      if (emit) begin
         rsp_fired_ff  <= emit_fired;
         rsp_id_ff     <= emit_id;
         rsp_status_ff <= emit_status;
         rsp_last_ff   <= emit_last;
      end
      if (state_ff == ST_TCHK && fire_go) begin
         cap_id_ff  <= cell_data[0].id;
         cap_due_ff <= cell_data[0].due;
      end
      // Advance the firing timer by one period.
      if (state_ff == ST_TFIRE) begin
         new_due_ff <= cap_due_ff + TIME_W'(q_ff[cap_ide[SIW-1:0]]) + TIME_W'(frac_carry);
         frac_ff[cap_ide[SIW-1:0]] <= frac_carry ?
            REM_W'(frac_sum - (REM_W+1)'(US_PER_MS)) : REM_W'(frac_sum);
      end
      if (state_ff == ST_INS) begin
         q_ff[req_ide[SIW-1:0]]    <= div_q;
         r_ff[req_ide[SIW-1:0]]    <= div_r;
         frac_ff[req_ide[SIW-1:0]] <= div_r;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.fired    = rsp_fired_ff;
   assign rsp_chan.fired_id = rsp_id_ff;
   assign rsp_chan.status   = rsp_status_ff;
   assign rsp_chan.last     = rsp_last_ff;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the periodic timer scheduler.
module tb_top;
   import pts_pkg::*;

   localparam int NSLOT = DEF_MAX_TIMERS;
   localparam int FIRE_CAP = DEF_MAX_FIRES;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [TID_W-1:0]  timer_id;
      logic [IVAL_W-1:0] interval_us;
      logic [TIME_W-1:0] now_ms;
   } request_type;

   typedef struct packed {
      logic                fired;
      logic [TID_W-1:0]    fired_id;
      logic [STATUS_W-1:0] status;
      logic                last;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pts_req_if req_chan ();
   pts_rsp_if rsp_chan ();

   periodic_timer_scheduler u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: timer slots and the due-ordered queue.
   bit                arm_active [NSLOT];
   logic [IVAL_W-1:0] arm_period [NSLOT];
   logic [TIME_W-1:0] arm_due    [NSLOT];
   logic [9:0]        arm_frac   [NSLOT];
   int                due_order  [$];

   request_type  pending_requests [$];
   response_type awaited_responses [$];
   int  fail_count = 0;
   bit  no_idle = 1'b0;
   bit  send_pause = 1'b0;
   bit  req_taken = 1'b0;
   int  hold_off_cycles = 0;
   int  idle_cycles = 0;

   // Place a slot after every entry that is due no later than it.
   task automatic order_insert(input int id);
      int pos;
      pos = 0;
      while (pos < due_order.size() && arm_due[due_order[pos]] <= arm_due[id])
         pos++;
      due_order.insert(pos, id);
   endtask

   task automatic order_delete(input int id);
      for (int i = due_order.size() - 1; i >= 0; i--) begin
         if (due_order[i] == id) due_order.delete(i);
      end
   endtask

   task automatic push_response(input logic f, input int id, input logic [1:0] st,
                                input logic lst);
      response_type r;
      r.fired = f;
      r.fired_id = TID_W'(id);
      r.status = st;
      r.last = lst;
      awaited_responses.push_back(r);
   endtask

   // Compute the responses a request causes and update the predictor.
   task automatic predict_schedule(input request_type q);
      int n;
      int s;
      logic [10:0] frac;
      int id;
      id = q.timer_id;
      case (q.mode)
         MODE_INSTALL: begin
            if (arm_active[id]) begin
               push_response(1'b0, 0, STAT_DUPLICATE, 1'b1);
            end else begin
               arm_active[id] = 1'b1;
               arm_period[id] = q.interval_us;
               arm_due[id] = q.now_ms + q.interval_us / US_PER_MS;
               arm_frac[id] = 10'(q.interval_us % US_PER_MS);
               order_insert(id);
               push_response(1'b0, 0, STAT_OK, 1'b1);
            end
         end
         MODE_REMOVE: begin
            if (!arm_active[id]) begin
               push_response(1'b0, 0, STAT_NOT_PRESENT, 1'b1);
            end else begin
               order_delete(id);
               arm_active[id] = 1'b0;
               push_response(1'b0, 0, STAT_OK, 1'b1);
            end
         end
         MODE_TICK: begin
            n = 0;
            while (n < FIRE_CAP && due_order.size() > 0) begin
               s = due_order[0];
               if (!(arm_due[s] < q.now_ms)) break;
               void'(due_order.pop_front());
               arm_due[s] += arm_period[s] / US_PER_MS;
               frac = 11'(arm_frac[s] + arm_period[s] % US_PER_MS);
               if (frac >= US_PER_MS) begin
                  arm_due[s] += 1;
                  frac = frac - 11'(US_PER_MS);
               end
               arm_frac[s] = frac[9:0];
               order_insert(s);
               push_response(1'b1, s, STAT_OK, 1'b0);
               n++;
            end
            if (n == 0) push_response(1'b0, 0, STAT_OK, 1'b1);
            else awaited_responses[awaited_responses.size() - 1].last = 1'b1;
         end
         default: push_response(1'b0, 0, STAT_OK, 1'b1);
      endcase
   endtask

   // Request driver: offers queued requests, changes at the falling edge.
   initial begin
      req_chan.valid = 1'b0;
      req_chan.mode = '0;
      req_chan.timer_id = '0;
      req_chan.interval_us = '0;
      req_chan.now_ms = '0;
      rsp_chan.ready = 1'b0;
   end

   // Remember whether the offered request was taken at the last rising edge.
   always @(posedge clock) begin
      req_taken <= req_chan.valid && req_chan.ready;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (pending_requests.size() > 0 && !send_pause &&
             (no_idle || $urandom_range(99) >= 6)) begin
            request_type q;
            q = pending_requests.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.mode <= q.mode;
            req_chan.timer_id <= q.timer_id;
            req_chan.interval_us <= q.interval_us;
            req_chan.now_ms <= q.now_ms;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Response ready: random idling plus one long hold-off.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !reset && (no_idle || $urandom_range(99) >= 6);
      end
   end

   // Monitor: predict on each accepted request, check each response.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            request_type q;
            q.mode = req_chan.mode;
            q.timer_id = req_chan.timer_id;
            q.interval_us = req_chan.interval_us;
            q.now_ms = req_chan.now_ms;
            predict_schedule(q);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_responses.size() == 0) begin
               $error("unexpected response fired=%0d id=%0d", rsp_chan.fired,
                      rsp_chan.fired_id);
               fail_count++;
            end else begin
               response_type e;
               e = awaited_responses.pop_front();
               if (rsp_chan.fired !== e.fired) begin
                  $error("fired: expected %0d actual %0d", e.fired, rsp_chan.fired);
                  fail_count++;
               end
               if (rsp_chan.fired_id !== e.fired_id) begin
                  $error("fired_id: expected %0d actual %0d", e.fired_id,
                         rsp_chan.fired_id);
                  fail_count++;
               end
               if (rsp_chan.status !== e.status) begin
                  $error("status: expected %0d actual %0d", e.status, rsp_chan.status);
                  fail_count++;
               end
               if (rsp_chan.last !== e.last) begin
                  $error("last: expected %0d actual %0d", e.last, rsp_chan.last);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog on cycles with no accepted request or response.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic add_request(input logic [1:0] m, input int id, input logic [30:0] iv,
                              input logic [31:0] t);
      request_type q;
      q.mode = m;
      q.timer_id = TID_W'(id);
      q.interval_us = iv;
      q.now_ms = t;
      pending_requests.push_back(q);
   endtask

   task automatic drain_all();
      while (pending_requests.size() > 0 || req_chan.valid ||
             awaited_responses.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Random interval, mostly short so timers fire often.
   function automatic logic [30:0] pick_interval();
      case ($urandom_range(9))
         0: return 31'd0;
         1: return 31'($urandom);
         2: return 31'h7fffffff;
         default: return 31'($urandom_range(1, 9999));
      endcase
   endfunction

   initial begin
      logic [31:0] clk_ms;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: statuses, unused mode, zero period, cap, wraparound.
      add_request(MODE_TICK, 0, 31'd0, 32'd100);
      add_request(MODE_REMOVE, 3, 31'd0, 32'd0);
      add_request(MODE_INSTALL, 3, 31'd1500, 32'd10);
      add_request(MODE_INSTALL, 3, 31'd1500, 32'd10);
      add_request(MODE_UNUSED, 15, 31'h7fffffff, 32'hffffffff);
      add_request(MODE_TICK, 0, 31'd0, 32'd14);
      add_request(MODE_TICK, 0, 31'd0, 32'd14);
      add_request(MODE_REMOVE, 3, 31'd0, 32'd0);
      add_request(MODE_INSTALL, 0, 31'd0, 32'd5);
      add_request(MODE_TICK, 0, 31'd0, 32'd6);
      add_request(MODE_REMOVE, 0, 31'd0, 32'd0);
      add_request(MODE_INSTALL, 15, 31'h7fffffff, 32'hffffffff);
      add_request(MODE_INSTALL, 7, 31'd999, 32'hfffffff0);
      add_request(MODE_TICK, 0, 31'd0, 32'hffffffff);
      add_request(MODE_TICK, 0, 31'd0, 32'h0);
      add_request(MODE_REMOVE, 15, 31'd0, 32'd0);
      add_request(MODE_REMOVE, 7, 31'd0, 32'd0);
      for (int i = 0; i < NSLOT; i++) add_request(MODE_INSTALL, i, 31'd1, 32'd0);
      drain_all();

      // Cap test under a long receiver hold-off: many due timers at once.
      hold_off_cycles = 400;
      add_request(MODE_TICK, 0, 31'd0, 32'd50);
      add_request(MODE_TICK, 0, 31'd0, 32'd50);
      for (int i = 0; i < NSLOT; i++) add_request(MODE_REMOVE, i, 31'd0, 32'd0);
      drain_all();

      // Random part: a time base advancing with ticks and installs nearby.
      clk_ms = $urandom;
      for (int k = 0; k < 380; k++) begin
         if (k == 150) no_idle = 1'b1;
         if (k == 250) no_idle = 1'b0;
         if (k == 300) begin
            drain_all();
            send_pause = 1'b1;
            repeat (30) @(posedge clock);
            send_pause = 1'b0;
         end
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               clk_ms += $urandom_range(0, 12);
               add_request(MODE_TICK, 0, 31'($urandom), clk_ms);
            end
            4, 5, 6: add_request(MODE_INSTALL, $urandom_range(15), pick_interval(),
                                 ($urandom_range(15) == 0) ? $urandom : clk_ms);
            7, 8: add_request(MODE_REMOVE, $urandom_range(15), 31'($urandom), $urandom);
            default: begin
               if ($urandom_range(1)) add_request(MODE_UNUSED, $urandom_range(15),
                                                  31'($urandom), $urandom);
               else add_request(MODE_TICK, 0, 31'd0, $urandom);
            end
         endcase
      end
      drain_all();

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
